### rtl/core/tfrc_pkg.sv
// constants and codes shared by the telemetry frame receiver
// no dependencies
`timescale 1ns / 1ps

package tfrc_pkg;

   localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
   localparam logic [7:0]  SYNC_SECOND = 8'h5A;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_TOPBIT  = 16'h8000;

   typedef logic [2:0] frame_pos_type;

   // position in the frame, i.e. what the next byte is
   localparam frame_pos_type POS_HUNT   = 3'd0;
   localparam frame_pos_type POS_SYNC1  = 3'd1;
   localparam frame_pos_type POS_LEN    = 3'd2;
   localparam frame_pos_type POS_SEQ    = 3'd3;
   localparam frame_pos_type POS_STATE  = 3'd4;
   localparam frame_pos_type POS_FLAGS  = 3'd5;
   localparam frame_pos_type POS_CRC_LO = 3'd6;
   localparam frame_pos_type POS_CRC_HI = 3'd7;

endpackage

### rtl/core/tfrc_stream_if.sv
// valid/ready channel interfaces for the received byte and the frame result
// depends on nothing; fields match the block's payload widths
`timescale 1ns / 1ps

interface tfrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] seq_number;
   logic [7:0] machine_state;
   logic [7:0] flag_bits;

   modport source (output valid, output seq_number, output machine_state,
                   output flag_bits, input ready);
   modport sink   (input valid, input seq_number, input machine_state,
                   input flag_bits, output ready);
endinterface

### rtl/core/tfrc_crc_step.sv
// bytewise crc16-ccitt update, msb first, no reflection
// depends on tfrc_pkg
`timescale 1ns / 1ps

module tfrc_crc_step
   import tfrc_pkg::*;
(
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_in,
   output logic [15:0] crc_out
);

   always_comb begin
      logic [15:0] c;
      c = crc_in ^ {data_in, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOPBIT) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_out = c;
   end

endmodule

### rtl/core/telemetry_frame_receiver_crc16.sv
// sync-header telemetry frame receiver with crc16-ccitt check
// depends on tfrc_pkg, tfrc_stream_if and tfrc_crc_step
//
//   channel   dir   payload                                  role
//   req_if    in    rx_byte                                  one received byte
//   rsp_if    out   seq_number, machine_state, flag_bits     one checked frame
//
// one byte per cycle sustained unless a last-crc byte stalls (see below): the input register feeds the frame tracker,
// which updates the crc over one byte and loads the result register.
// a result is registered once the last crc byte leaves the input register with a crc match.
// synchronous reset clears the valids and the frame position and sets the crc to CRC_INIT.
// only a last-crc byte waits in the input register while an earlier result
// is still untaken; every other byte moves on regardless of rsp_if.ready.
`timescale 1ns / 1ps

module telemetry_frame_receiver_crc16
   import tfrc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tfrc_req_if.sink   req_if,
   tfrc_rsp_if.source rsp_if
);

   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_byte_ff;
   frame_pos_type frame_pos_ff, frame_pos_in;
   logic [15:0]   crc_ff, crc_in;
   logic [15:0]   crc_next;
   logic [7:0]    held_seq_ff, held_state_ff, held_flags_ff, held_crc_low_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_seq_ff, rsp_state_ff, rsp_flags_ff;
   logic          s1_advance;
   logic          crc_match;
   logic          emit;
   logic          req_take;

   tfrc_crc_step u_crc (
      .crc_in  (crc_ff),
      .data_in (s1_byte_ff),
      .crc_out (crc_next)
   );

   // a last-crc byte needs the result register free
   assign s1_advance = s1_valid_ff &&
                       ((frame_pos_ff != POS_CRC_HI) || !rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_advance;
   assign req_take = req_if.valid && req_if.ready;

   assign crc_match = ({s1_byte_ff, held_crc_low_ff} == crc_ff);
   assign emit = s1_advance && (frame_pos_ff == POS_CRC_HI) && crc_match;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      frame_pos_in = frame_pos_ff;
      crc_in = crc_ff;
      if (s1_advance) begin
         case (frame_pos_ff)
            POS_HUNT: begin
               if (s1_byte_ff == SYNC_FIRST) frame_pos_in = POS_SYNC1;
            end
            POS_SYNC1: begin
               if (s1_byte_ff == SYNC_SECOND) begin
                  frame_pos_in = POS_LEN;
                  crc_in = CRC_INIT;
               end else if (s1_byte_ff == SYNC_FIRST) begin
                  frame_pos_in = POS_SYNC1;
               end else begin
                  frame_pos_in = POS_HUNT;
               end
            end
            POS_LEN, POS_SEQ, POS_STATE, POS_FLAGS: begin
               crc_in = crc_next;
               frame_pos_in = frame_pos_ff + 3'd1;
            end
            POS_CRC_LO: frame_pos_in = POS_CRC_HI;
            default:    frame_pos_in = POS_HUNT;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (emit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         frame_pos_ff <= POS_HUNT;
         crc_ff       <= CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         frame_pos_ff <= frame_pos_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) s1_byte_ff <= req_if.rx_byte;
      if (s1_advance) begin
         if (frame_pos_ff == POS_SEQ)    held_seq_ff     <= s1_byte_ff;
         if (frame_pos_ff == POS_STATE)  held_state_ff   <= s1_byte_ff;
         if (frame_pos_ff == POS_FLAGS)  held_flags_ff   <= s1_byte_ff;
         if (frame_pos_ff == POS_CRC_LO) held_crc_low_ff <= s1_byte_ff;
      end
      if (emit) begin
         rsp_seq_ff   <= held_seq_ff;
         rsp_state_ff <= held_state_ff;
         rsp_flags_ff <= held_flags_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.seq_number    = rsp_seq_ff;
   assign rsp_if.machine_state = rsp_state_ff;
   assign rsp_if.flag_bits     = rsp_flags_ff;

   // a new result only follows a last-crc byte, and the hunt restarts
   a_result_after_crc: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(frame_pos_ff) == POS_CRC_HI) &&
                              (frame_pos_ff == POS_HUNT))
      else $error("result without a completed frame");

   // completing the sync restarts the crc
   a_sync_crc_init: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && (frame_pos_ff == POS_SYNC1) && (s1_byte_ff == SYNC_SECOND))
      |=> (crc_ff == CRC_INIT) && (frame_pos_ff == POS_LEN))
      else $error("crc not restarted after sync");

   // the input register only stalls behind an untaken result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |->
         rsp_valid_ff && !rsp_if.ready && (frame_pos_ff == POS_CRC_HI))
      else $error("input stalled without a pending result");

   // a stalled input register blocks new transfers
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |-> !req_if.ready)
      else $error("transfer accepted over a stalled byte");

endmodule

### tb/tfrc_frame_checker.sv
// frame result checker for the telemetry frame receiver: predicts results from
// the received bytes and compares them with what the block returns
// depends on tfrc_pkg; holds the crc helper shared with the stimulus
`timescale 1ns / 1ps

package tfrc_tb_crc_pkg;
   import tfrc_pkg::*;

   // crc16-ccitt over one byte, msb first
   function automatic logic [15:0] crc16_ccitt_step(input logic [15:0] crc,
                                                     input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction
endpackage

module tfrc_frame_checker
   import tfrc_pkg::*;
   import tfrc_tb_crc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_seq_number,
   input  logic [7:0] rsp_machine_state,
   input  logic [7:0] rsp_flag_bits,
   output int         fail_count,
   output int         pending_frames
);

   typedef struct packed {
      logic [7:0] seq_number;
      logic [7:0] machine_state;
      logic [7:0] flag_bits;
   } frame_result_type;

   frame_result_type expected_frames[$];

   frame_pos_type frame_pos;
   logic [15:0]   running_crc;
   logic [7:0]    held_seq;
   logic [7:0]    held_state;
   logic [7:0]    held_flags;
   logic [7:0]    held_crc_low;
   int            mismatches;

   initial begin
      mismatches = 0;
   end

   task automatic compare_field(input string label, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      if (reset) begin
         frame_pos   = POS_HUNT;
         running_crc = CRC_INIT;
         expected_frames.delete();
      end else begin
         // a result can never come from the byte taken at this same edge
         if (rsp_valid && rsp_ready) begin
            got = {rsp_seq_number, rsp_machine_state, rsp_flag_bits};
            if (expected_frames.size() == 0) begin
               $display("%0t: unexpected frame result: expected none, actual %h %h %h",
                        $time, got.seq_number, got.machine_state, got.flag_bits);
               mismatches++;
            end else begin
               want = expected_frames.pop_front();
               compare_field("seq_number", want.seq_number, got.seq_number);
               compare_field("machine_state", want.machine_state, got.machine_state);
               compare_field("flag_bits", want.flag_bits, got.flag_bits);
            end
         end

         if (req_valid && req_ready) begin
            case (frame_pos)
               POS_HUNT: begin
                  if (req_rx_byte == SYNC_FIRST) frame_pos = POS_SYNC1;
               end
               POS_SYNC1: begin
                  if (req_rx_byte == SYNC_SECOND) begin
                     frame_pos   = POS_LEN;
                     running_crc = CRC_INIT;
                  end else if (req_rx_byte != SYNC_FIRST) begin
                     frame_pos = POS_HUNT;
                  end
               end
               POS_LEN: begin
                  running_crc = crc16_ccitt_step(running_crc, req_rx_byte);
                  frame_pos   = POS_SEQ;
               end
               POS_SEQ: begin
                  held_seq    = req_rx_byte;
                  running_crc = crc16_ccitt_step(running_crc, req_rx_byte);
                  frame_pos   = POS_STATE;
               end
               POS_STATE: begin
                  held_state  = req_rx_byte;
                  running_crc = crc16_ccitt_step(running_crc, req_rx_byte);
                  frame_pos   = POS_FLAGS;
               end
               POS_FLAGS: begin
                  held_flags  = req_rx_byte;
                  running_crc = crc16_ccitt_step(running_crc, req_rx_byte);
                  frame_pos   = POS_CRC_LO;
               end
               POS_CRC_LO: begin
                  held_crc_low = req_rx_byte;
                  frame_pos    = POS_CRC_HI;
               end
               default: begin
                  frame_pos = POS_HUNT;
                  // crc travels little-endian
                  if ({req_rx_byte, held_crc_low} == running_crc) begin
                     expected_frames.push_back({held_seq, held_state, held_flags});
                  end
               end
            endcase
         end
      end
      fail_count     <= mismatches;
      pending_frames <= expected_frames.size();
   end

endmodule

### tb/tb_telemetry_frame_receiver_crc16.sv
// testbench top for the telemetry frame receiver: reset, byte stimulus,
// random stalls on both channels, watchdog and verdict
// depends on tfrc_pkg, tfrc_stream_if, the receiver and tfrc_frame_checker
`timescale 1ns / 1ps

module tb_telemetry_frame_receiver_crc16;
   import tfrc_pkg::*;
   import tfrc_tb_crc_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_BYTES = 1950;
   localparam int IDLE_LIMIT   = 1000;
   localparam int DRAIN_CYCLES = 10;

   localparam int WAIT_UNIFORM = 0;
   localparam int WAIT_NONE    = 1;
   localparam int WAIT_SPARSE  = 2;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending_frames;
   int   bytes_sent;
   int   send_mode;
   int   sink_mode;

   tfrc_req_if req_if ();
   tfrc_rsp_if rsp_if ();

   always #2 clock = ~clock;

   telemetry_frame_receiver_crc16 DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   tfrc_frame_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_if.valid),
      .req_ready         (req_if.ready),
      .req_rx_byte       (req_if.rx_byte),
      .rsp_valid         (rsp_if.valid),
      .rsp_ready         (rsp_if.ready),
      .rsp_seq_number    (rsp_if.seq_number),
      .rsp_machine_state (rsp_if.machine_state),
      .rsp_flag_bits     (rsp_if.flag_bits),
      .fail_count        (fail_count),
      .pending_frames    (pending_frames)
   );

   function automatic int pick_wait(input int mode);
      case (mode)
         WAIT_UNIFORM: return $urandom_range(0, 14);
         WAIT_NONE:    return 0;
         default:      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
      endcase
   endfunction

   function automatic logic [7:0] rand_field();
      logic [7:0] corners [6];
      corners = '{8'h00, 8'hFF, SYNC_FIRST, SYNC_SECOND, 8'h80, 8'h7F};
      if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 5)];
      return 8'($urandom_range(0, 255));
   endfunction

   // valid stays high across back-to-back transfers
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = pick_wait(send_mode);
      if ($urandom_range(0, 39) == 0) send_mode = $urandom_range(0, 2);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= value;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   task automatic send_frame(input int lead_count, input logic [7:0] len,
                             input logic [7:0] seq, input logic [7:0] state,
                             input logic [7:0] flags, input bit corrupt);
      logic [7:0]  body [6];
      logic [15:0] crc;
      int          flip;
      crc = crc16_ccitt_step(CRC_INIT, len);
      crc = crc16_ccitt_step(crc, seq);
      crc = crc16_ccitt_step(crc, state);
      crc = crc16_ccitt_step(crc, flags);
      body = '{len, seq, state, flags, crc[7:0], crc[15:8]};
      if (corrupt) begin
         flip = $urandom_range(0, 47);
         body[flip / 8] = body[flip / 8] ^ (8'h01 << (flip % 8));
      end
      repeat (lead_count) send_byte(SYNC_FIRST);
      send_byte(SYNC_SECOND);
      foreach (body[i]) send_byte(body[i]);
   endtask

   initial begin : result_sink
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = pick_wait(sink_mode);
         if ($urandom_range(0, 39) == 0) sink_mode = $urandom_range(0, 2);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      int kind;
      int target;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = 8'h00;
      rsp_if.ready   = 1'b0;
      bytes_sent     = 0;
      send_mode      = WAIT_UNIFORM;
      sink_mode      = WAIT_UNIFORM;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // noise, then a first sync byte followed by a non-sync byte
      send_byte(8'h00);
      send_byte(SYNC_FIRST);
      send_byte(8'h00);
      // all-zero frame, then a repeated first sync byte with all-ones fields
      send_frame(1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      send_frame(2, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      // crc mismatch drops the frame
      send_frame(1, 8'h80, 8'h7F, SYNC_FIRST, SYNC_SECOND, 1'b1);

      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            send_frame(1, rand_field(), rand_field(), rand_field(), rand_field(), 1'b0);
         end else if (kind < 80) begin
            send_frame(1, rand_field(), rand_field(), rand_field(), rand_field(), 1'b1);
         end else if (kind < 88) begin
            // frame cut short; the following bytes finish it
            send_byte(SYNC_FIRST);
            send_byte(SYNC_SECOND);
            repeat ($urandom_range(0, 5)) send_byte(rand_field());
         end else if (kind < 94) begin
            send_frame($urandom_range(2, 5), rand_field(), rand_field(), rand_field(),
                       rand_field(), 1'b0);
         end else begin
            repeat ($urandom_range(1, 8)) send_byte(rand_field());
         end
      end
      req_if.valid <= 1'b0;

      // let the checker count the last transfer before waiting on it
      @(posedge clock);
      while (pending_frames != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending_frames == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### sim.f
rtl/core/tfrc_pkg.sv
rtl/core/tfrc_stream_if.sv
rtl/core/tfrc_crc_step.sv
rtl/core/telemetry_frame_receiver_crc16.sv
tb/tfrc_frame_checker.sv
tb/tb_telemetry_frame_receiver_crc16.sv
